### sv/tcv_pkg.sv
// ----------------------------------------------------------------------------
// tcv_pkg
// Shared types and constants for the TCP-over-IPv4 checksum verifier.
// ----------------------------------------------------------------------------
package tcv_pkg;

    // Status codes of a result beat
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_SHORT      = 3'd1;
    localparam logic [2:0] ST_BAD_HDR    = 3'd2;
    localparam logic [2:0] ST_BAD_TOTAL  = 3'd3;
    localparam logic [2:0] ST_MISMATCH   = 3'd4;

    // Byte positions within the IPv4 header
    localparam logic [15:0] POS_VER_IHL  = 16'd0;
    localparam logic [15:0] POS_TLEN_HI  = 16'd2;
    localparam logic [15:0] POS_TLEN_LO  = 16'd3;
    localparam logic [15:0] POS_ADDR_LO  = 16'd12;
    localparam logic [15:0] POS_ADDR_HI  = 16'd19;

    localparam logic [15:0] COUNT_MAX    = 16'hffff;
    localparam logic [15:0] MIN_PKT_LEN  = 16'd40;
    localparam logic [5:0]  MIN_HDR_LEN  = 6'd20;
    localparam logic [6:0]  MIN_SEG_LEN  = 7'd20;
    localparam logic [31:0] TCP_PROTO    = 32'd6;
    localparam logic [15:0] FOLD_ONES    = 16'hffff;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic       checksum_ok;
        logic [2:0] status;
    } out_beat_t;

    // Per-packet state captured on the last byte
    typedef struct packed {
        logic [15:0] pkt_len;
        logic [5:0]  hdr_bytes;
        logic [15:0] total_len;
        logic [31:0] sum;
        logic [7:0]  pend_high;
    } snap_t;

endpackage

### sv/tcv_accum.sv
// ----------------------------------------------------------------------------
// tcv_accum
// Per-byte packet tracker: header fields, byte position and word sum.
// ----------------------------------------------------------------------------
module tcv_accum (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              beat_accept,
    input  tcv_pkg::in_beat_t beat,
    output logic              snap_valid,
    output tcv_pkg::snap_t    snap
);

    logic [15:0] count_reg, count_next;
    logic [5:0]  hdr_reg, hdr_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [31:0] sum_reg, sum_next;
    logic [7:0]  high_reg, high_next;
    logic        take;

    always_comb begin
        hdr_next  = hdr_reg;
        tlen_next = tlen_reg;
        sum_next  = sum_reg;
        high_next = high_reg;

        if (count_reg == tcv_pkg::POS_VER_IHL) begin
            hdr_next = {beat.data_byte[3:0], 2'b00};
        end else if (count_reg == tcv_pkg::POS_TLEN_HI) begin
            tlen_next = {beat.data_byte, tlen_reg[7:0]};
        end else if (count_reg == tcv_pkg::POS_TLEN_LO) begin
            tlen_next = {tlen_reg[15:8], beat.data_byte};
        end

        // addresses always count; segment bytes only inside [hdr, total)
        take = (count_reg >= tcv_pkg::POS_ADDR_LO && count_reg <= tcv_pkg::POS_ADDR_HI)
            || (count_reg >= {10'd0, hdr_next} && count_reg < tlen_next);

        if (take) begin
            if (!count_reg[0]) begin
                high_next = beat.data_byte;
            end else begin
                sum_next = sum_reg + {16'd0, high_reg, beat.data_byte};
            end
        end

        count_next = (count_reg == tcv_pkg::COUNT_MAX) ? count_reg : count_reg + 16'd1;
    end

    assign snap_valid     = beat_accept && beat.last_byte;
    assign snap.pkt_len   = count_next;
    assign snap.hdr_bytes = hdr_next;
    assign snap.total_len = tlen_next;
    assign snap.sum       = sum_next;
    assign snap.pend_high = high_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || snap_valid) begin
            count_reg <= '0;
            hdr_reg   <= '0;
            tlen_reg  <= '0;
            sum_reg   <= '0;
            high_reg  <= '0;
        end else if (beat_accept) begin
            count_reg <= count_next;
            hdr_reg   <= hdr_next;
            tlen_reg  <= tlen_next;
            sum_reg   <= sum_next;
            high_reg  <= high_next;
        end
    end

endmodule

### sv/tcv_verdict.sv
// ----------------------------------------------------------------------------
// tcv_verdict
// Verdict pipeline: length checks and final add, then fold and compare.
// ----------------------------------------------------------------------------
module tcv_verdict (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               snap_valid,
    input  tcv_pkg::snap_t     snap,
    output logic               snap_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output tcv_pkg::out_beat_t m_data
);

    logic               fin_valid_reg;
    tcv_pkg::snap_t     fin_reg;
    logic               mid_valid_reg;
    logic [2:0]         mid_st_reg, mid_st_next;
    logic [31:0]        mid_acc_reg, mid_acc_next;
    logic               res_valid_reg;
    tcv_pkg::out_beat_t res_reg, res_next;

    logic        res_load, mid_load, mid_free;
    logic [6:0]  hdr_plus;
    logic [15:0] seg_len;
    logic [31:0] pad;
    logic [16:0] fold1, fold2;
    logic        sum_ok;

    assign res_load   = mid_valid_reg && (!res_valid_reg || m_ready);
    assign mid_free   = !mid_valid_reg || res_load;
    assign mid_load   = fin_valid_reg && mid_free;
    assign snap_ready = !fin_valid_reg || mid_free;

    // length checks and unfolded sum
    always_comb begin
        hdr_plus = {1'b0, fin_reg.hdr_bytes} + tcv_pkg::MIN_SEG_LEN;
        seg_len  = fin_reg.total_len - {10'd0, fin_reg.hdr_bytes};
        pad      = seg_len[0] ? {16'd0, fin_reg.pend_high, 8'd0} : 32'd0;
        mid_acc_next = fin_reg.sum + pad + tcv_pkg::TCP_PROTO + {16'd0, seg_len};

        if (fin_reg.pkt_len < tcv_pkg::MIN_PKT_LEN) begin
            mid_st_next = tcv_pkg::ST_SHORT;
        end else if (fin_reg.hdr_bytes < tcv_pkg::MIN_HDR_LEN
                     || fin_reg.pkt_len < {9'd0, hdr_plus}) begin
            mid_st_next = tcv_pkg::ST_BAD_HDR;
        end else if (fin_reg.total_len > fin_reg.pkt_len
                     || fin_reg.total_len < {10'd0, fin_reg.hdr_bytes}) begin
            mid_st_next = tcv_pkg::ST_BAD_TOTAL;
        end else begin
            mid_st_next = tcv_pkg::ST_OK;
        end
    end

    // end-around carry fold, then compare against all ones
    always_comb begin
        fold1  = {1'b0, mid_acc_reg[15:0]} + {1'b0, mid_acc_reg[31:16]};
        fold2  = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
        sum_ok = (fold2[15:0] == tcv_pkg::FOLD_ONES);

        if (mid_st_reg != tcv_pkg::ST_OK) begin
            res_next.status = mid_st_reg;
        end else if (sum_ok) begin
            res_next.status = tcv_pkg::ST_OK;
        end else begin
            res_next.status = tcv_pkg::ST_MISMATCH;
        end
        res_next.checksum_ok = (res_next.status == tcv_pkg::ST_OK);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
            mid_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (snap_ready) begin
                fin_valid_reg <= snap_valid;
            end
            if (mid_free) begin
                mid_valid_reg <= fin_valid_reg;
            end
            if (!res_valid_reg || m_ready) begin
                res_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_ready && snap_valid) begin
            fin_reg <= snap;
        end
        if (mid_load) begin
            mid_st_reg  <= mid_st_next;
            mid_acc_reg <= mid_acc_next;
        end
        if (res_load) begin
            res_reg <= res_next;
        end
    end

    assign m_valid = res_valid_reg;
    assign m_data  = res_reg;

endmodule

### sv/tcp_checksum_verifier.sv
// ----------------------------------------------------------------------------
// tcp_checksum_verifier
// Streaming TCP-over-IPv4 checksum check, one packet byte per beat.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries the packet one byte per beat, starting at IPv4 header byte 0;
//   last_byte marks the final byte. Each packet yields one m_* beat holding
//   checksum_ok and a status (ok, too short, bad header length, bad total
//   length, checksum mismatch). Non-final bytes produce nothing.
//   Throughput: one byte per cycle while s_ready is high, set by the single
//   32-bit word add in the byte accumulator; packets may follow each other
//   with no gap. The edge that accepts the last byte captures the packet
//   state in fin_reg; the checks and the unfolded sum are then registered in
//   mid_*, and the folded verdict in res_reg, which drives m_valid.
//   Reset clears the per-packet state and empties the result pipeline.
//   When m_ready is low, results collect in the three pipeline registers;
//   s_ready drops only once a finished packet can no longer move forward,
//   and bytes keep flowing until then.
// ----------------------------------------------------------------------------
module tcp_checksum_verifier (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tcv_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tcv_pkg::out_beat_t m_data
);

    logic           beat_accept;
    logic           snap_valid;
    tcv_pkg::snap_t snap;

    assign beat_accept = s_valid && s_ready;

    tcv_accum u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat_accept (beat_accept),
        .beat        (s_data),
        .snap_valid  (snap_valid),
        .snap        (snap)
    );

    tcv_verdict u_verdict (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .snap_valid (snap_valid),
        .snap       (snap),
        .snap_ready (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // ok flag must agree with the status code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.checksum_ok == (m_data.status == tcv_pkg::ST_OK)))
        else $error("checksum_ok disagrees with status");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status <= tcv_pkg::ST_MISMATCH))
        else $error("status code out of range");

    // reset empties the result pipeline
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming TCP-over-IPv4 checksum verifier.
// Directed packets cover the short, bad-header, bad-total, mismatch, odd
// segment, link padding and byte-count saturation cases. Random packets,
// mostly well formed with a valid checksum, follow. Every byte is run
// through a local model that predicts the verdict unless a directed row gives its own.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        int         ihl_nib;
        int         total;
        int         len;
        bit         fix;
        bit         corrupt;
        int         fill;     // negative: random bytes, else every byte holds this value
        bit         typed;
        logic [2:0] st;
    } pkt_row_t;

    localparam pkt_row_t DIRECTED [19] = '{
        '{5,     0,     1, 1'b0, 1'b0, 255, 1'b1, tcv_pkg::ST_SHORT},
        '{5,     0,     1, 1'b0, 1'b0,   0, 1'b1, tcv_pkg::ST_SHORT},
        '{5,    39,    39, 1'b1, 1'b0,  -1, 1'b1, tcv_pkg::ST_SHORT},
        '{5,    40,    40, 1'b1, 1'b0,  -1, 1'b1, tcv_pkg::ST_OK},
        '{0,    44,    44, 1'b0, 1'b0,   0, 1'b1, tcv_pkg::ST_BAD_HDR},
        '{15,   70,    70, 1'b0, 1'b0, 255, 1'b1, tcv_pkg::ST_BAD_HDR},
        '{4,    60,    60, 1'b1, 1'b0,  -1, 1'b1, tcv_pkg::ST_BAD_HDR},
        '{15,   80,    80, 1'b1, 1'b0,  -1, 1'b1, tcv_pkg::ST_OK},
        '{15,   79,    79, 1'b1, 1'b0,  -1, 1'b1, tcv_pkg::ST_BAD_HDR},
        '{5,    61,    60, 1'b1, 1'b0,  -1, 1'b1, tcv_pkg::ST_BAD_TOTAL},
        '{5,    19,    60, 1'b1, 1'b0,  -1, 1'b1, tcv_pkg::ST_BAD_TOTAL},
        '{5, 65535,    60, 1'b1, 1'b0,  -1, 1'b1, tcv_pkg::ST_BAD_TOTAL},
        '{5,    20,    40, 1'b1, 1'b0,  -1, 1'b0, tcv_pkg::ST_OK},
        '{5,    61,    61, 1'b1, 1'b0,  -1, 1'b1, tcv_pkg::ST_OK},
        '{5,    50,    64, 1'b1, 1'b0,  -1, 1'b1, tcv_pkg::ST_OK},
        '{5,    41,    48, 1'b1, 1'b0,  -1, 1'b1, tcv_pkg::ST_OK},
        '{5,    60,    60, 1'b1, 1'b1,  -1, 1'b1, tcv_pkg::ST_MISMATCH},
        '{5,    45,    45, 1'b0, 1'b0,  -1, 1'b0, tcv_pkg::ST_OK},
        '{5, 65535, 65600, 1'b1, 1'b0,  -1, 1'b1, tcv_pkg::ST_OK}
    };

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    tcv_pkg::in_beat_t  s_data;
    logic               m_valid;
    logic               m_ready;
    tcv_pkg::out_beat_t m_data;

    // packet model state
    logic [15:0] byte_pos = '0;
    logic [5:0]  hdr_len  = '0;
    logic [15:0] tot_len  = '0;
    logic [31:0] word_sum = '0;
    logic [7:0]  hi_byte  = '0;

    logic [7:0]         pkt_bytes [$];
    tcv_pkg::out_beat_t verdict_q [$];
    int                 fail_count = 0;
    int                 bytes_sent = 0;
    int                 cycles     = 0;
    bit                 typed_on   = 1'b0;
    logic [2:0]         typed_st   = tcv_pkg::ST_OK;
    bit                 rx_hold    = 1'b0;

    tcp_checksum_verifier dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [2:0] pkt_verdict(input logic [15:0] len);
        int                 l;
        int                 ihl;
        int                 total;
        int                 seg;
        logic [31:0]        acc;
        l     = len;
        ihl   = hdr_len;
        total = tot_len;
        if (l < 40)
            return tcv_pkg::ST_SHORT;
        if (ihl < 20 || l < ihl + 20)
            return tcv_pkg::ST_BAD_HDR;
        if (total > l || total < ihl)
            return tcv_pkg::ST_BAD_TOTAL;
        seg = total - ihl;
        acc = word_sum;
        // pad an odd final segment byte with a zero low byte
        if (seg % 2 != 0)
            acc += {hi_byte, 8'h00};
        acc += 32'd6 + 32'(seg);
        acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
        acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
        return (acc[15:0] == 16'hffff) ? tcv_pkg::ST_OK : tcv_pkg::ST_MISMATCH;
    endfunction

    task automatic checksum_step(input tcv_pkg::in_beat_t bt, output bit done,
                                 output tcv_pkg::out_beat_t res);
        logic [15:0] pos;
        logic [2:0]  st;
        pos = byte_pos;
        if (pos == 16'd0)
            hdr_len = {bt.data_byte[3:0], 2'b00};
        else if (pos == 16'd2)
            tot_len[15:8] = bt.data_byte;
        else if (pos == 16'd3)
            tot_len[7:0] = bt.data_byte;
        if ((pos >= 16'd12 && pos <= 16'd19) ||
            (pos >= 16'(hdr_len) && pos < tot_len)) begin
            if (!pos[0])
                hi_byte = bt.data_byte;
            else
                word_sum += {16'h0, hi_byte, bt.data_byte};
        end
        if (byte_pos != 16'hffff)
            byte_pos++;
        done = bt.last_byte;
        res  = '0;
        if (done) begin
            st  = pkt_verdict(byte_pos);
            res = '{checksum_ok: (st == tcv_pkg::ST_OK), status: st};
            byte_pos = '0;
            hdr_len  = '0;
            tot_len  = '0;
            word_sum = '0;
            hi_byte  = '0;
        end
    endtask

    // one's-complement sum of the pseudo header and segment, folded
    function automatic logic [15:0] pkt_fold(input int hdr, input int seg);
        logic [31:0] acc;
        int          i;
        acc = 32'd6 + 32'(seg);
        for (i = 12; i < 20; i += 2)
            acc += {16'h0, pkt_bytes[i], pkt_bytes[i + 1]};
        for (i = 0; i < seg; i += 2)
            acc += {16'h0, pkt_bytes[hdr + i], (i + 1 < seg) ? pkt_bytes[hdr + i + 1] : 8'h00};
        acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
        acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
        return acc[15:0];
    endfunction

    task automatic build_pkt(input pkt_row_t row);
        int          i;
        int          hdr;
        int          seg;
        int          at;
        logic [15:0] w;
        pkt_bytes.delete();
        for (i = 0; i < row.len; i++)
            pkt_bytes.push_back(row.fill < 0 ? 8'($urandom_range(0, 255)) : 8'(row.fill));
        if (row.fill >= 0)
            return;
        pkt_bytes[0] = {4'($urandom_range(0, 15)), 4'(row.ihl_nib)};
        if (row.len > 3) begin
            pkt_bytes[2] = row.total[15:8];
            pkt_bytes[3] = row.total[7:0];
        end
        hdr = row.ihl_nib * 4;
        seg = row.total - hdr;
        if (hdr < 20 || row.total > row.len || seg < 1)
            return;
        // place the checksum word: TCP checksum field if it fits, else first word
        if (row.fix && seg >= 2) begin
            at = hdr + ((seg >= 18) ? 16 : 0);
            pkt_bytes[at]     = 8'h00;
            pkt_bytes[at + 1] = 8'h00;
            w = ~pkt_fold(hdr, seg);
            pkt_bytes[at]     = w[15:8];
            pkt_bytes[at + 1] = w[7:0];
        end
        // a single bit flip always breaks a one's-complement sum
        if (row.corrupt) begin
            at = $urandom_range(hdr, row.total - 1);
            pkt_bytes[at] = pkt_bytes[at] ^ (8'h01 << $urandom_range(0, 7));
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input bit last, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_byte: b, last_byte: last};
        @(posedge aclk);
        while (!(s_valid && s_ready))
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_pkt(input bit burst);
        int i;
        for (i = 0; i < pkt_bytes.size(); i++)
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1,
                      burst ? 0 : $urandom_range(0, 17));
        bytes_sent += pkt_bytes.size();
    endtask

    // result sink: random per-beat stalls, bursts of no stall, one long hold-off
    initial begin : sink
        int gap;
        int hold_cnt;
        bit rx_burst;
        rx_burst = 1'b0;
        m_ready  = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (rx_hold) begin
                rx_hold = 1'b0;
                m_ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(negedge aclk);
            end
            if ($urandom_range(0, 15) == 0)
                rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready))
                @(posedge aclk);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin : monitor
        bit                 done;
        tcv_pkg::out_beat_t res;
        tcv_pkg::out_beat_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                checksum_step(s_data, done, res);
                if (done) begin
                    if (typed_on) begin
                        res.status      = typed_st;
                        res.checksum_ok = (typed_st == tcv_pkg::ST_OK);
                        typed_on        = 1'b0;
                    end
                    verdict_q.push_back(res);
                end
            end
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat: ok=%0b status=%0d",
                                 m_data.checksum_ok, m_data.status);
                end else begin
                    want = verdict_q.pop_front();
                    if (m_data.checksum_ok !== want.checksum_ok ||
                        m_data.status !== want.status) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"verdict mismatch: expected ok=%0b status=%0d, ",
                                      "got ok=%0b status=%0d"},
                                     want.checksum_ok, want.status,
                                     m_data.checksum_ok, m_data.status);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge aclk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int       r;
        int       n;
        int       kind;
        int       k;
        pkt_row_t row;
        s_valid = 1'b0;
        s_data  = '0;
        aresetn = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (r = 0; r < $size(DIRECTED); r++) begin
            row = DIRECTED[r];
            build_pkt(row);
            typed_on = row.typed;
            typed_st = row.st;
            send_pkt(row.len > 1000 || $urandom_range(0, 3) == 0);
        end

        bytes_sent = 0;
        n = 0;
        while (bytes_sent < 1600) begin
            // stall the sink and push a burst of tiny packets into the pipeline
            if (n == 5) begin
                rx_hold = 1'b1;
                for (k = 0; k < 12; k++) begin
                    row = '{5, 0, $urandom_range(1, 3), 1'b0, 1'b0, -1, 1'b0, tcv_pkg::ST_OK};
                    build_pkt(row);
                    send_pkt(1'b1);
                end
            end
            kind = $urandom_range(0, 9);
            row  = '{5, 0, 0, 1'b1, 1'b0, -1, 1'b0, tcv_pkg::ST_OK};
            if (kind <= 6) begin
                row.ihl_nib = ($urandom_range(0, 2) == 0) ? $urandom_range(5, 15) : 5;
                row.total   = row.ihl_nib * 4 + $urandom_range(20, 60);
                row.len     = row.total + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
                row.corrupt = ($urandom_range(0, 4) == 0);
            end else if (kind == 7) begin
                row.ihl_nib = $urandom_range(0, 15);
                row.total   = $urandom_range(0, 80);
                row.len     = $urandom_range(1, 45);
                row.fix     = 1'b0;
            end else begin
                row.ihl_nib = $urandom_range(0, 15);
                row.len     = $urandom_range(40, 100);
                row.total   = $urandom_range(0, 1) ? $urandom_range(0, 120)
                                                   : row.len - $urandom_range(0, 3);
            end
            build_pkt(row);
            send_pkt($urandom_range(0, 3) == 0);
            n++;
        end
        s_valid <= 1'b0;

        while (verdict_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
